FILE: src/cwl_pkg.sv
// Types and codes shared by the card identifier whitelist table.
package cwl_pkg;

    localparam logic [1:0] CLS_MASTER = 2'd0;
    localparam logic [1:0] CLS_USER   = 2'd1;
    localparam logic [1:0] CLS_UNAUTH = 2'd2;

    localparam logic [2:0] OUT_NONE    = 3'd0;
    localparam logic [2:0] OUT_REMOVED = 3'd1;
    localparam logic [2:0] OUT_ADDED   = 3'd2;
    localparam logic [2:0] OUT_FULL    = 3'd3;
    localparam logic [2:0] OUT_LEAVE   = 3'd4;

    typedef struct packed {
        logic        action;
        logic [31:0] card_id;
    } t_cwl_in;

    typedef struct packed {
        logic [1:0] card_class;
        logic [2:0] outcome;
        logic [6:0] user_count;
    } t_cwl_out;

endpackage

FILE: src/cwl_ram.sv
// Generic single write, single read RAM with registered read data.
module cwl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/card_id_whitelist_table_core.sv
// Card identifier whitelist table: master check, linear table scan, add and remove.
// A master card or an empty table goes from idle straight to the decide state; any other
// card is first scanned through the table RAM read port at one entry a cycle, and a removal
// adds a move state. One item at a time; ready only when idle.
// Reset (synchronous, active low) empties the table and clears the master identifier.
module card_id_whitelist_table_core #(
    parameter int MAX_USERS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [31:0]       i_cfg_wr_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  cwl_pkg::t_cwl_in  i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output cwl_pkg::t_cwl_out o_result
);

    localparam int AW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
    localparam int CW = $clog2(MAX_USERS + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_MOVE   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_slot, n_slot;
    logic [31:0] r_id, n_id;
    logic        r_action, n_action;
    logic [1:0]  r_cls, n_cls;
    logic [2:0]  r_outc, n_outc;
    logic [31:0] r_master;
    logic        r_out_valid, n_out_valid;
    cwl_pkg::t_cwl_out r_result, n_result;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    logic          w_accept;
    logic [CW-1:0] w_last;
    logic [15:0]   w_cnt_ext;

    cwl_ram #(
        .WIDTH (32),
        .DEPTH (MAX_USERS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_ready   = (r_state == S_IDLE);
    assign w_accept  = i_valid && o_ready;
    assign w_last    = r_count - CW'(1);
    assign w_cnt_ext = 16'(r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_slot      = r_slot;
        n_id        = r_id;
        n_action    = r_action;
        n_cls       = r_cls;
        n_outc      = r_outc;
        n_out_valid = r_out_valid && !i_ready;
        n_result    = r_result;
        ram_we      = 1'b0;
        ram_waddr   = r_count[AW-1:0];
        ram_wdata   = r_id;
        ram_raddr   = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_id     = i_item.card_id;
                    n_action = i_item.action;
                    n_idx    = '0;
                    if (i_item.card_id == r_master) begin
                        n_cls   = cwl_pkg::CLS_MASTER;
                        n_state = S_DECIDE;
                    end else if (r_count == '0) begin
                        n_cls   = cwl_pkg::CLS_UNAUTH;
                        n_state = S_DECIDE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // ram_rdata holds entry r_idx
                if (ram_rdata == r_id) begin
                    n_cls   = cwl_pkg::CLS_USER;
                    n_slot  = r_idx;
                    n_state = S_DECIDE;
                end else if ((CW'(r_idx) + CW'(1)) == r_count) begin
                    n_cls   = cwl_pkg::CLS_UNAUTH;
                    n_state = S_DECIDE;
                end else begin
                    n_idx     = r_idx + 1'b1;
                    ram_raddr = r_idx + 1'b1;
                end
            end
            S_DECIDE: begin
                n_outc  = cwl_pkg::OUT_NONE;
                n_state = S_DONE;
                if (r_action) begin
                    case (r_cls)
                        cwl_pkg::CLS_MASTER: begin
                            n_outc = cwl_pkg::OUT_LEAVE;
                        end
                        cwl_pkg::CLS_USER: begin
                            ram_raddr = w_last[AW-1:0];
                            n_state   = S_MOVE;
                        end
                        default: begin
                            if (r_count >= CW'(MAX_USERS)) begin
                                n_outc = cwl_pkg::OUT_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + CW'(1);
                                n_outc  = cwl_pkg::OUT_ADDED;
                            end
                        end
                    endcase
                end
            end
            S_MOVE: begin
                // last entry fills the freed slot
                ram_we    = 1'b1;
                ram_waddr = r_slot;
                ram_wdata = ram_rdata;
                n_count   = w_last;
                n_outc    = cwl_pkg::OUT_REMOVED;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_result.card_class = r_cls;
                    n_result.outcome    = r_outc;
                    n_result.user_count = w_cnt_ext[6:0];
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_master    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_master <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_slot   <= n_slot;
        r_id     <= n_id;
        r_action <= n_action;
        r_cls    <= n_cls;
        r_outc   <= n_outc;
        r_result <= n_result;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_USERS))
        else $error("stored count beyond table depth");

    a_master_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_item.card_id == r_master) && !i_cfg_wr_en)
        |=> (r_cls == cwl_pkg::CLS_MASTER) && (r_state == S_DECIDE))
        else $error("master card not classed as master");

    a_write_admin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> r_action && ((r_state == S_DECIDE) || (r_state == S_MOVE)))
        else $error("table written outside administration");

endmodule
